// ----- rtl/sts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg - shared types and constants for the sun tracker servo stepper
// Mode codes, configuration indexes, reset values and the angle step function.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int THR_W           = 10;
  localparam int BAND_W          = 10;
  localparam int WIND_W          = 8;
  localparam int ANGLE_W         = 8;
  localparam int MODE_W          = 2;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 10;
  localparam int RATIO_SCALE     = 1000;

  localparam logic [THR_W-1:0]   NIGHT_THRESHOLD_RST = 10'd550;
  localparam logic [BAND_W-1:0]  DEADBAND_RST        = 10'd100;
  localparam logic [WIND_W-1:0]  WIND_LIMIT_RST      = 8'd20;
  localparam logic [ANGLE_W-1:0] STEP_SIZE_RST       = 8'd1;
  localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST       = 8'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST       = 8'd180;
  localparam logic [ANGLE_W-1:0] POSITION_RST        = 8'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_AUTO   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_NIGHT  = 2'd2,
    MODE_WIND   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NIGHT_THRESHOLD    = 3'd0,
    CFG_AZIMUTH_DEADBAND   = 3'd1,
    CFG_ELEVATION_DEADBAND = 3'd2,
    CFG_WIND_LIMIT         = 3'd3,
    CFG_STEP_SIZE          = 3'd4,
    CFG_ANGLE_MIN          = 3'd5,
    CFG_ANGLE_MAX          = 3'd6
  } cfg_idx_t;

  // Move request for one axis: lo when the ratio is under the band,
  // hi when it is over the band (or the divisor is zero).
  typedef struct packed {
    logic lo;
    logic hi;
  } axis_move_t;

  // Per-beat conditions the mode selector needs.
  typedef struct packed {
    logic              night;
    logic              manual;
    logic [WIND_W-1:0] wind_speed;
  } mode_req_t;

  // One step of an axis; a target past either end wraps to the other end.
  function automatic logic [ANGLE_W-1:0] step_angle(
    input logic [ANGLE_W-1:0] pos,
    input logic               up,
    input logic [ANGLE_W-1:0] step,
    input logic [ANGLE_W-1:0] amin,
    input logic [ANGLE_W-1:0] amax
  );
    logic [ANGLE_W:0]   sum;
    logic [ANGLE_W-1:0] diff;
    logic [ANGLE_W-1:0] res;
    sum  = {1'b0, pos} + {1'b0, step};
    diff = pos - step;
    if (step == '0) begin
      res = pos;
    end else if (up) begin
      if (sum > {1'b0, amax}) res = amin;
      else if (sum < {1'b0, amin}) res = amax;
      else res = sum[ANGLE_W-1:0];
    end else begin
      if (pos < step) res = amax;
      else if (diff > amax) res = amin;
      else if (diff < amin) res = amax;
      else res = diff;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sts_ratio_cmp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ratio_cmp - per-mille ratio test of two opposite light samples
// Compares a*1000 against (1000-band)*b and (1001+band)*b by cross-multiplying.
// ----------------------------------------------------------------------------
module sts_ratio_cmp #(
  parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0]    a,
  input  wire logic [SAMPLE_BITS-1:0]    b,
  input  wire logic [sts_pkg::BAND_W-1:0] band,
  output sts_pkg::axis_move_t             move
);

  localparam int NW = SAMPLE_BITS + 11;
  localparam logic [NW-1:0] SCALE = NW'(sts_pkg::RATIO_SCALE);

  logic                        lo_valid;
  logic [sts_pkg::BAND_W-1:0]  lo_bound;
  logic [sts_pkg::BAND_W:0]    hi_bound;
  logic [NW-1:0]               num;
  logic [NW-1:0]               prod_lo;
  logic [NW-1:0]               prod_hi;

  // A band above 1000 pushes the low bound below zero: no low move then.
  assign lo_valid = (band <= sts_pkg::BAND_W'(sts_pkg::RATIO_SCALE));
  assign lo_bound = sts_pkg::BAND_W'(sts_pkg::RATIO_SCALE) - band;
  assign hi_bound = (sts_pkg::BAND_W + 1)'(sts_pkg::RATIO_SCALE + 1) + {1'b0, band};

  assign num     = NW'(a) * SCALE;
  assign prod_lo = NW'(lo_bound) * NW'(b);
  assign prod_hi = NW'(hi_bound) * NW'(b);

  // A zero divisor reads as a huge ratio.
  assign move.lo = (b != '0) && lo_valid && (num < prod_lo);
  assign move.hi = (b == '0) || (num >= prod_hi);

endmodule
`default_nettype wire

// ----- rtl/sts_mode_sel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_mode_sel - mode priority with wind hysteresis
// Night wins, then wind, then the manual switch, else automatic tracking.
// ----------------------------------------------------------------------------
module sts_mode_sel (
  input  wire sts_pkg::mode_req_t         req,
  input  wire sts_pkg::mode_t             cur_mode,
  input  wire logic [sts_pkg::WIND_W-1:0] wind_limit,
  output sts_pkg::mode_t                  mode
);

  logic windy;

  // Wind mode is held at the limit and only entered above it.
  assign windy = (req.wind_speed > wind_limit) ||
                 ((cur_mode == sts_pkg::MODE_WIND) && (req.wind_speed >= wind_limit));

  always_comb begin
    if (req.night) mode = sts_pkg::MODE_NIGHT;
    else if (windy) mode = sts_pkg::MODE_WIND;
    else if (req.manual) mode = sts_pkg::MODE_MANUAL;
    else mode = sts_pkg::MODE_AUTO;
  end

endmodule
`default_nettype wire

// ----- rtl/sun_tracker_servo_stepper_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sun_tracker_servo_stepper_top - four-quadrant photosensor sun tracker
// Picks an operating mode per sensor beat and steps the two servo angles.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in_     | in  | tvalid/tready     | four light samples, manual switch, wind
//  out_    | out | tvalid/tready     | mode, two angles, two laid-down flags
//  cfg_    | in  | wen, no handshake | register index and data
//
// One beat is accepted per cycle unless a stall on out_tready holds it back.
// A beat passes through the input register (ratio cross-multiplies and the
// night mean), the decision register (mode choice and the angle step against
// the tracked state) and then sits in the output register behind out_tvalid.
// The mode and positions update when a beat leaves the decision register,
// so back-to-back beats see their predecessor's state. Reset (rst_n low,
// synchronous) empties all stages, loads the register defaults and sets
// automatic mode with both angles at zero. A stall on out_tready fills the
// stages one by one before in_tready drops.
// ----------------------------------------------------------------------------
module sun_tracker_servo_stepper_top #(
  parameter int SAMPLE_BITS = sts_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // east, west, north, south (SAMPLE_BITS each), manual_switch (1),
  // wind_speed_kmh (8), zero pad to whole bytes
  input  wire logic [((4*SAMPLE_BITS+1+sts_pkg::WIND_W+7)/8)*8-1:0] in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // mode (2), azimuth_angle (8), elevation_angle (8), elevation_laid_down (1),
  // mirror_laid_down (1), zero pad to 24 bits
  output logic [23:0]                             out_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_wen,
  input  wire logic [sts_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  wire logic [sts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW        = sts_pkg::ANGLE_W;
  localparam int IN_W      = 4*SAMPLE_BITS + 1 + sts_pkg::WIND_W;
  localparam int OUT_W     = sts_pkg::MODE_W + 2*AW + 2;
  localparam int SUM_W     = SAMPLE_BITS + 2;
  localparam int MEAN_CW   = (SAMPLE_BITS > sts_pkg::THR_W) ? SAMPLE_BITS : sts_pkg::THR_W;
  localparam int OFS_W     = SAMPLE_BITS;
  localparam int OFS_N     = 2*SAMPLE_BITS;
  localparam int OFS_S     = 3*SAMPLE_BITS;
  localparam int OFS_MAN   = 4*SAMPLE_BITS;
  localparam int OFS_WIND  = 4*SAMPLE_BITS + 1;

  // Configuration registers.
  logic [sts_pkg::THR_W-1:0]  night_threshold_r;
  logic [sts_pkg::BAND_W-1:0] azimuth_deadband_r;
  logic [sts_pkg::BAND_W-1:0] elevation_deadband_r;
  logic [sts_pkg::WIND_W-1:0] wind_limit_r;
  logic [AW-1:0]              step_size_r;
  logic [AW-1:0]              angle_min_r;
  logic [AW-1:0]              angle_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      night_threshold_r    <= sts_pkg::NIGHT_THRESHOLD_RST;
      azimuth_deadband_r   <= sts_pkg::DEADBAND_RST;
      elevation_deadband_r <= sts_pkg::DEADBAND_RST;
      wind_limit_r         <= sts_pkg::WIND_LIMIT_RST;
      step_size_r          <= sts_pkg::STEP_SIZE_RST;
      angle_min_r          <= sts_pkg::ANGLE_MIN_RST;
      angle_max_r          <= sts_pkg::ANGLE_MAX_RST;
    end else if (cfg_wen) begin
      case (sts_pkg::cfg_idx_t'(cfg_addr))
        sts_pkg::CFG_NIGHT_THRESHOLD:    night_threshold_r    <= cfg_wdata;
        sts_pkg::CFG_AZIMUTH_DEADBAND:   azimuth_deadband_r   <= cfg_wdata;
        sts_pkg::CFG_ELEVATION_DEADBAND: elevation_deadband_r <= cfg_wdata;
        sts_pkg::CFG_WIND_LIMIT:         wind_limit_r         <= cfg_wdata[sts_pkg::WIND_W-1:0];
        sts_pkg::CFG_STEP_SIZE:          step_size_r          <= cfg_wdata[AW-1:0];
        sts_pkg::CFG_ANGLE_MIN:          angle_min_r          <= cfg_wdata[AW-1:0];
        sts_pkg::CFG_ANGLE_MAX:          angle_max_r          <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes: each stage loads when it is empty or draining.
  logic s1_valid_r;
  logic s2_valid_r;
  logic out_valid_r;
  logic out_load;
  logic s2_adv;
  logic s1_adv;
  logic in_acc;

  assign out_load  = !out_valid_r || out_tready;
  assign s2_adv    = s2_valid_r && out_load;
  assign s1_adv    = s1_valid_r && (!s2_valid_r || s2_adv);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (!s2_valid_r || s2_adv) s2_valid_r <= s1_adv;
      if (out_load) out_valid_r <= s2_adv;
    end
  end

  // Stage 1: input register, ratio tests and night test.
  logic [IN_W-1:0] s1_data_r;

  always_ff @(posedge clk) begin
    if (in_acc) s1_data_r <= in_tdata[IN_W-1:0];
  end

  logic [SAMPLE_BITS-1:0]    s1_east;
  logic [SAMPLE_BITS-1:0]    s1_west;
  logic [SAMPLE_BITS-1:0]    s1_north;
  logic [SAMPLE_BITS-1:0]    s1_south;
  logic [SUM_W-1:0]          s1_sum;
  logic [MEAN_CW-1:0]        s1_mean;
  sts_pkg::axis_move_t       s1_az_move;
  sts_pkg::axis_move_t       s1_el_move;
  sts_pkg::mode_req_t        s1_req;

  assign s1_east  = s1_data_r[OFS_W-1:0];
  assign s1_west  = s1_data_r[OFS_N-1:OFS_W];
  assign s1_north = s1_data_r[OFS_S-1:OFS_N];
  assign s1_south = s1_data_r[OFS_MAN-1:OFS_S];
  assign s1_sum   = SUM_W'(s1_east) + SUM_W'(s1_west) + SUM_W'(s1_north) + SUM_W'(s1_south);
  assign s1_mean  = MEAN_CW'(s1_sum[SUM_W-1:2]);

  assign s1_req.night      = s1_mean < MEAN_CW'(night_threshold_r);
  assign s1_req.manual     = s1_data_r[OFS_MAN];
  assign s1_req.wind_speed = s1_data_r[IN_W-1:OFS_WIND];

  sts_ratio_cmp #(.SAMPLE_BITS(SAMPLE_BITS)) u_az_cmp (
    .a    (s1_east),
    .b    (s1_west),
    .band (azimuth_deadband_r),
    .move (s1_az_move)
  );

  sts_ratio_cmp #(.SAMPLE_BITS(SAMPLE_BITS)) u_el_cmp (
    .a    (s1_north),
    .b    (s1_south),
    .band (elevation_deadband_r),
    .move (s1_el_move)
  );

  // Stage 2: decision register, mode choice and angle stepping.
  sts_pkg::axis_move_t s2_az_move_r;
  sts_pkg::axis_move_t s2_el_move_r;
  sts_pkg::mode_req_t  s2_req_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_az_move_r <= s1_az_move;
      s2_el_move_r <= s1_el_move;
      s2_req_r     <= s1_req;
    end
  end

  sts_pkg::mode_t current_mode_r;
  logic [AW-1:0]  az_pos_r;
  logic [AW-1:0]  el_pos_r;
  sts_pkg::mode_t mode_nxt;
  logic [AW-1:0]  az_pos_nxt;
  logic [AW-1:0]  el_pos_nxt;

  sts_mode_sel u_mode_sel (
    .req        (s2_req_r),
    .cur_mode   (current_mode_r),
    .wind_limit (wind_limit_r),
    .mode       (mode_nxt)
  );

  // Azimuth: east weaker than west steps up, stronger steps down.
  // Elevation: north weaker than south steps down, stronger steps up.
  always_comb begin
    az_pos_nxt = az_pos_r;
    el_pos_nxt = el_pos_r;
    if (mode_nxt == sts_pkg::MODE_AUTO) begin
      if (s2_az_move_r.lo) begin
        az_pos_nxt = sts_pkg::step_angle(az_pos_r, 1'b1, step_size_r, angle_min_r, angle_max_r);
      end else if (s2_az_move_r.hi) begin
        az_pos_nxt = sts_pkg::step_angle(az_pos_r, 1'b0, step_size_r, angle_min_r, angle_max_r);
      end
      if (s2_el_move_r.lo) begin
        el_pos_nxt = sts_pkg::step_angle(el_pos_r, 1'b0, step_size_r, angle_min_r, angle_max_r);
      end else if (s2_el_move_r.hi) begin
        el_pos_nxt = sts_pkg::step_angle(el_pos_r, 1'b1, step_size_r, angle_min_r, angle_max_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_mode_r <= sts_pkg::MODE_AUTO;
      az_pos_r       <= sts_pkg::POSITION_RST;
      el_pos_r       <= sts_pkg::POSITION_RST;
    end else if (s2_adv) begin
      current_mode_r <= mode_nxt;
      az_pos_r       <= az_pos_nxt;
      el_pos_r       <= el_pos_nxt;
    end
  end

  // Output register.
  logic [OUT_W-1:0] out_fields_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_fields_r <= {mode_nxt == sts_pkg::MODE_WIND, mode_nxt == sts_pkg::MODE_NIGHT,
                       el_pos_nxt, az_pos_nxt, mode_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 24'(out_fields_r);

  // A beat in the output register always carries the mode now held in state.
  a_mode_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fields_r[sts_pkg::MODE_W-1:0] == current_mode_r))
    else $error("output mode differs from tracked mode");

  // Positions never move outside automatic mode.
  a_hold_outside_auto: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && (mode_nxt != sts_pkg::MODE_AUTO)) |=>
      (az_pos_r == $past(az_pos_r)) && (el_pos_r == $past(el_pos_r)))
    else $error("angle moved outside automatic mode");

  // Wind mode is only entered from another mode above the limit.
  a_wind_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && (mode_nxt == sts_pkg::MODE_WIND) && (current_mode_r != sts_pkg::MODE_WIND))
      |-> (s2_req_r.wind_speed > wind_limit_r))
    else $error("wind mode entered at or below the limit");

  // A beat leaving stage 1 lands in stage 2.
  a_no_beat_lost: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> s2_valid_r)
    else $error("beat dropped between stages");

endmodule
`default_nettype wire
